// ----- hdl/gblur_pkg.sv -----
// Package with constants and types shared by the 3x3 blur stream modules.
package gblur_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_HEIGHT   = 4095;

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 4;
  localparam int WIN_TAPS   = 6;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  // Frame geometry, stored as last index of each dimension.
  typedef struct packed {
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [CH_W-1:0]  nc_m1;
  } geom_t;

  // Everything the datapath needs to know about one accepted item.
  typedef struct packed {
    logic [LINE_AW-1:0] addr;
    logic [ROW_W-1:0]   row_m1;
    logic [COL_W-1:0]   col_m1;
    logic [CH_W-1:0]    ch;
    logic               has_result;
    logic               frame_last;
  } item_info_t;

endpackage

// ----- hdl/gblur_if.sv -----
// Stream and configuration channel interfaces of the 3x3 blur block.
interface gblur_in_if
  import gblur_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gblur_out_if
  import gblur_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] filtered_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_column;
  logic [CH_W-1:0]  out_channel;
  logic             frame_last;

  modport source (output valid, output filtered_value, output out_row, output out_column,
                  output out_channel, output frame_last, input ready);
  modport sink (input valid, input filtered_value, input out_row, input out_column,
                input out_channel, input frame_last, output ready);
endinterface

interface gblur_cfg_if
  import gblur_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/gaussian_blur_3x3_stream.sv -----
// Top level of the 3x3 binomial blur for interleaved multi-channel pixel streams.
//
// The block takes one 8-bit channel sample per item on in_ch, in raster order with the
// channels of a pixel interleaved. Frame geometry is set through cfg_ch: index 0 is the
// image width, 1 the height, 2 the channel count. Any write to one of these restarts
// the frame at row 0, column 0, channel 0; writes are taken every cycle.
// For each sample at row r, column x with r and x both at least 2, out_ch gives the
// blurred value of the sample one row up and one column back, with its row, column and
// channel; frame_last marks the final interior result of the frame. Border samples
// produce no result and just update the line stores and window.
// out_ch.valid comes from the output register, after stage one. Throughput is one item
// per cycle unless the output stalls: an item reads its line memory entry when accepted,
// writes it back on leaving stage one, and the per-channel window is read and shifted.
// Reset restores the default 640x480 three-channel geometry, clears the position
// counters and empties the pipeline; line memory and window are not cleared, since
// every entry is written in a frame before its value reaches a result.
// When the receiver stalls, the result sits in the output register. Items without a
// result keep flowing; the next item with a result stops in stage one and in_ch.ready
// drops until the output register is taken.
module gaussian_blur_3x3_stream
  import gblur_pkg::*;
  (
  input  logic        clk,
  input  logic        rst_n,
  gblur_cfg_if.sink   cfg_ch,
  gblur_in_if.sink    in_ch,
  gblur_out_if.source out_ch
);

  item_info_t         pos;
  geom_t              geom;
  logic               in_fire, s1_fire;
  logic [2*PIX_W-1:0] line_rd;
  logic [PIX_W-1:0]   filtered;

  // Stage one: item whose line memory read is returning.
  logic               s1_valid_r, s1_valid_nxt;
  item_info_t         s1_info_r;
  logic [PIX_W-1:0]   s1_sample_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_value_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [CH_W-1:0]    out_ch_r;
  logic               out_last_r;

  assign cfg_ch.ready = 1'b1;

  // A stage-one item moves on unless it has a result and the output is still full.
  assign s1_fire     = s1_valid_r && (!s1_info_r.has_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  gblur_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid && cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .item_fire (in_fire),
    .info      (pos),
    .geom      (geom)
  );

  // Upper byte holds row r-2, lower byte row r-1 of the same slot.
  gblur_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (pos.addr),
    .rd_data (line_rd),
    .wr_en   (s1_fire),
    .wr_addr (s1_info_r.addr),
    .wr_data ({line_rd[PIX_W-1:0], s1_sample_r})
  );

  gblur_window u_window (
    .clk      (clk),
    .upd_en   (s1_fire),
    .ch       (s1_info_r.ch),
    .top      (line_rd[2*PIX_W-1:PIX_W]),
    .mid      (line_rd[PIX_W-1:0]),
    .bot      (s1_sample_r),
    .filtered (filtered)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_info_r.has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_info_r   <= pos;
      s1_sample_r <= in_ch.sample;
    end
    if (s1_fire && s1_info_r.has_result) begin
      out_value_r <= filtered;
      out_row_r   <= s1_info_r.row_m1;
      out_col_r   <= s1_info_r.col_m1;
      out_ch_r    <= s1_info_r.ch;
      out_last_r  <= s1_info_r.frame_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_value = out_value_r;
  assign out_ch.out_row        = out_row_r;
  assign out_ch.out_column     = out_col_r;
  assign out_ch.out_channel    = out_ch_r;
  assign out_ch.frame_last     = out_last_r;

  // A new read never hits the entry that stage one is writing back in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_fire) |-> (pos.addr != s1_info_r.addr))
    else $error("line memory read and write back address the same entry");

  // The returned line data must hold while stage one waits on the output.
  a_line_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> $stable(line_rd))
    else $error("line memory data changed under a stalled item");

  // Results only come from interior pixels.
  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r != '0 && out_col_r != '0))
    else $error("result given for a border pixel");

  // The frame end mark sits on the last interior column and last channel.
  a_frame_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_col_r == geom.w_m1 - COL_W'(1) && out_ch_r == geom.nc_m1))
    else $error("frame end mark on the wrong position");

endmodule

// ----- hdl/gblur_ctrl.sv -----
// Geometry registers and raster position counters of the 3x3 blur block.
module gblur_ctrl
  import gblur_pkg::*;
  (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic                 item_fire,
  output item_info_t           info,
  output geom_t                geom
);

  geom_t              geom_r, geom_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [LINE_AW-1:0] addr_r, addr_nxt;

  logic [COL_W:0]   w_raw, w_sat;
  logic [ROW_W-1:0] h_raw, h_sat;
  logic [2:0]       nc_raw, nc_sat;
  logic             last_ch, last_col, last_row;
  logic             restart;

  // Saturate written values to the supported geometry.
  always_comb begin
    w_raw  = cfg_data[COL_W:0];
    h_raw  = cfg_data[ROW_W-1:0];
    nc_raw = cfg_data[2:0];
    if (w_raw < (COL_W+1)'(3)) begin
      w_sat = (COL_W+1)'(3);
    end else if (w_raw > (COL_W+1)'(MAX_WIDTH)) begin
      w_sat = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_sat = w_raw;
    end
    h_sat = (h_raw < ROW_W'(3)) ? ROW_W'(3) : h_raw;
    if (nc_raw == 3'd0) begin
      nc_sat = 3'd1;
    end else if (nc_raw > 3'(MAX_CHANNELS)) begin
      nc_sat = 3'(MAX_CHANNELS);
    end else begin
      nc_sat = nc_raw;
    end
  end

  assign last_ch  = (ch_r == geom_r.nc_m1);
  assign last_col = (col_r == geom_r.w_m1);
  assign last_row = (row_r == geom_r.h_m1);

  always_comb begin
    geom_nxt = geom_r;
    restart  = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          geom_nxt.w_m1 = COL_W'(w_sat - (COL_W+1)'(1));
          restart       = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          geom_nxt.h_m1 = h_sat - ROW_W'(1);
          restart       = 1'b1;
        end
        REG_CHANNEL_COUNT: begin
          geom_nxt.nc_m1 = CH_W'(nc_sat - 3'd1);
          restart        = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    ch_nxt   = ch_r;
    addr_nxt = addr_r;
    if (restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      ch_nxt   = '0;
      addr_nxt = '0;
    end else if (item_fire) begin
      if (!last_ch) begin
        ch_nxt   = ch_r + CH_W'(1);
        addr_nxt = addr_r + LINE_AW'(1);
      end else begin
        ch_nxt = '0;
        if (!last_col) begin
          col_nxt  = col_r + COL_W'(1);
          addr_nxt = addr_r + LINE_AW'(1);
        end else begin
          col_nxt  = '0;
          addr_nxt = '0;
          row_nxt  = last_row ? '0 : row_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.w_m1  <= COL_W'(639);
      geom_r.h_m1  <= ROW_W'(479);
      geom_r.nc_m1 <= CH_W'(2);
      row_r        <= '0;
      col_r        <= '0;
      ch_r         <= '0;
      addr_r       <= '0;
    end else begin
      geom_r <= geom_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      ch_r   <= ch_nxt;
      addr_r <= addr_nxt;
    end
  end

  always_comb begin
    info.addr       = addr_r;
    info.row_m1     = row_r - ROW_W'(1);
    info.col_m1     = col_r - COL_W'(1);
    info.ch         = ch_r;
    info.has_result = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
    info.frame_last = last_row && last_col && last_ch;
  end

  assign geom = geom_r;

endmodule

// ----- hdl/gblur_line_mem.sv -----
// Line store memory: one entry holds the two previous rows of one sample slot.
module gblur_line_mem
  import gblur_pkg::*;
  (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [LINE_AW-1:0]   rd_addr,
  output logic [2*PIX_W-1:0]   rd_data,
  input  logic                 wr_en,
  input  logic [LINE_AW-1:0]   wr_addr,
  input  logic [2*PIX_W-1:0]   wr_data
);

  logic [2*PIX_W-1:0] mem [LINE_DEPTH];
  logic [2*PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/gblur_window.sv -----
// Per-channel 3x3 window columns and the binomial weighted sum.
module gblur_window
  import gblur_pkg::*;
  (
  input  logic             clk,
  input  logic             upd_en,
  input  logic [CH_W-1:0]  ch,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] bot,
  output logic [PIX_W-1:0] filtered
);

  // Taps 0..2 hold column x-2 (top, mid, bottom), taps 3..5 column x-1.
  logic [PIX_W-1:0] win_r [MAX_CHANNELS][WIN_TAPS];
  logic [SUM_W-1:0] col_old, col_prev, col_new, sum;

  always_comb begin
    col_old  = SUM_W'(win_r[ch][0]) + (SUM_W'(win_r[ch][1]) << 1) + SUM_W'(win_r[ch][2]);
    col_prev = SUM_W'(win_r[ch][3]) + (SUM_W'(win_r[ch][4]) << 1) + SUM_W'(win_r[ch][5]);
    col_new  = SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(bot);
    sum      = col_old + (col_prev << 1) + col_new;
  end

  assign filtered = sum[SUM_W-1:4];

  always_ff @(posedge clk) begin
    if (upd_en) begin
      win_r[ch][0] <= win_r[ch][3];
      win_r[ch][1] <= win_r[ch][4];
      win_r[ch][2] <= win_r[ch][5];
      win_r[ch][3] <= top;
      win_r[ch][4] <= mid;
      win_r[ch][5] <= bot;
    end
  end

endmodule
